// ===== hw/rtl/bpq_pkg.sv =====
package bpq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_BYTES   = 1'd0,
        REG_BLOCKS_IN_USE = 1'd1
    } cfg_reg_e;

    localparam logic [12:0] BLOCK_BYTES_RST   = 13'd16;
    localparam logic [6:0]  BLOCKS_IN_USE_RST = 7'd64;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_ALLOC = 3'd1,
        ACT_FREE  = 3'd2,
        ACT_QADD  = 3'd3,
        ACT_QTOP  = 3'd4,
        ACT_QDEL  = 3'd5
    } action_e;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_POOL_EMPTY  = 2'd1,
        ST_QUEUE_EMPTY = 2'd2
    } status_e;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] block_index;
        logic [1:0] queue_id;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  result_index;
        logic [17:0] result_offset;
        logic [6:0]  free_count;
    } out_t;

endpackage

// ===== hw/rtl/bpq_link_mem.sv =====
module bpq_link_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/block_pool_with_linked_queues.sv =====
// states from accept to result: rejected/unused requests S_FIN; free S_POP, S_FIN;
// alloc, queue top S_RD, S_POP, S_FIN; queue add also S_LINK before S_FIN; init S_INIT
// per clamped block, S_FIN; queue delete S_RD, S_POP per block, S_FIN; a stall holds S_FIN
// throughput: one request at a time; the next is taken the cycle after the result registers
// the link memory (one write, one registered read per cycle) sets these state sequences
// reset: pool empty, all queues empty, link memory left unwritten, no clearing pass
module block_pool_with_linked_queues #(
    parameter int BLOCK_COUNT = 64,
    parameter int NUM_QUEUES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bpq_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bpq_pkg::out_t                       out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import bpq_pkg::*;

    localparam int IW = $clog2(BLOCK_COUNT);
    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(BLOCK_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RD,
        S_POP,
        S_LINK,
        S_FIN
    } state_t;

    function automatic logic is_null(input logic [LW-1:0] v);
        return 32'(v) >= BLOCK_COUNT;
    endfunction

    state_t          state_reg;
    action_e         act_reg;
    logic [5:0]      bidx_reg;
    logic [QW-1:0]   qsel_reg;
    logic [1:0]      status_reg;
    logic [IW-1:0]   res_reg;
    logic [LW-1:0]   cnt_reg;
    logic [LW-1:0]   swp_reg;
    logic [LW-1:0]   free_head_reg;
    logic [LW-1:0]   free_total_reg;
    logic [LW-1:0]   queue_first_reg [NUM_QUEUES];
    logic [IW-1:0]   queue_last_reg  [NUM_QUEUES];
    logic [12:0]     block_bytes_reg;
    logic [6:0]      blocks_in_use_reg;
    logic            out_valid_reg;
    out_t            out_data_reg;

    logic [LW-1:0]   lim;
    logic [LW-1:0]   lim_m1;
    logic [LW-1:0]   tot_inc;
    logic [LW-1:0]   tot_dec;
    logic [LW-1:0]   qf_cur;
    logic [LW-1:0]   qf_in;
    logic            qok_in;
    logic            bidx_ok;
    logic [LW-1:0]   lnk;
    logic [31:0]     res_ext;
    logic [5:0]      res6;
    logic [18:0]     prod;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [LW-1:0]   wr_data;
    logic [IW-1:0]   rd_addr;
    logic [LW-1:0]   rd_data;

    bpq_link_mem #(
        .DEPTH (BLOCK_COUNT),
        .WIDTH (LW)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pool extent clamped to 1..BLOCK_COUNT
    always_comb
    begin
        if (blocks_in_use_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (32'(blocks_in_use_reg) > BLOCK_COUNT)
        begin
            lim = NULL_LINK;
        end
        else
        begin
            lim = LW'(blocks_in_use_reg);
        end
    end

    assign lim_m1  = lim - LW'(1);
    assign tot_inc = (free_total_reg < lim) ? LW'(free_total_reg + LW'(1)) : lim;
    assign tot_dec = (free_total_reg != '0) ? LW'(free_total_reg - LW'(1)) : '0;
    assign qf_cur  = queue_first_reg[qsel_reg];
    assign qok_in  = 32'(in_data.queue_id) < NUM_QUEUES;
    assign qf_in   = queue_first_reg[QW'(in_data.queue_id)];
    assign bidx_ok = 32'(bidx_reg) < BLOCK_COUNT;
    assign lnk     = is_null(rd_data) ? NULL_LINK : rd_data;
    assign res_ext = 32'(res_reg);
    assign res6    = res_ext[5:0];
    assign prod    = 19'(res6) * 19'(block_bytes_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (act_reg == ACT_ALLOC || act_reg == ACT_QADD)
        begin
            rd_addr = free_head_reg[IW-1:0];
        end
        else
        begin
            rd_addr = qf_cur[IW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = swp_reg[IW-1:0];
        wr_data = free_head_reg;
        unique case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = (swp_reg == lim_m1) ? NULL_LINK : LW'(swp_reg + LW'(1));
            end
            S_POP:
            begin
                unique case (act_reg)
                    ACT_FREE:
                    begin
                        wr_en   = bidx_ok;
                        wr_addr = IW'(bidx_reg);
                    end
                    ACT_QADD:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = free_head_reg[IW-1:0];
                        wr_data = NULL_LINK;
                    end
                    ACT_QTOP, ACT_QDEL:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = qf_cur[IW-1:0];
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            S_LINK:
            begin
                wr_en   = !is_null(qf_cur);
                wr_addr = queue_last_reg[qsel_reg];
                wr_data = LW'(res_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_head_reg     <= NULL_LINK;
            free_total_reg    <= '0;
            block_bytes_reg   <= BLOCK_BYTES_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
            act_reg           <= ACT_INIT;
            bidx_reg          <= '0;
            qsel_reg          <= '0;
            status_reg        <= ST_OK;
            res_reg           <= '0;
            cnt_reg           <= '0;
            swp_reg           <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                queue_first_reg[q] <= NULL_LINK;
                queue_last_reg[q]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_BLOCK_BYTES:   block_bytes_reg   <= cfg_data;
                    REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[6:0];
                    default:           block_bytes_reg   <= block_bytes_reg;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg    <= action_e'(in_data.action);
                        bidx_reg   <= in_data.block_index;
                        qsel_reg   <= QW'(in_data.queue_id);
                        status_reg <= ST_OK;
                        res_reg    <= '0;
                        cnt_reg    <= '0;
                        swp_reg    <= '0;
                        unique case (in_data.action)
                            ACT_INIT:
                            begin
                                state_reg <= S_INIT;
                            end
                            ACT_ALLOC:
                            begin
                                if (is_null(free_head_reg))
                                begin
                                    status_reg <= ST_POOL_EMPTY;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            ACT_FREE:
                            begin
                                state_reg <= S_POP;
                            end
                            ACT_QADD:
                            begin
                                if (!qok_in)
                                begin
                                    status_reg <= ST_QUEUE_EMPTY;
                                    state_reg  <= S_FIN;
                                end
                                else if (is_null(free_head_reg))
                                begin
                                    status_reg <= ST_POOL_EMPTY;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            ACT_QTOP, ACT_QDEL:
                            begin
                                if (!qok_in || is_null(qf_in))
                                begin
                                    status_reg <= ST_QUEUE_EMPTY;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_INIT:
                begin
                    if (swp_reg == lim_m1)
                    begin
                        free_head_reg  <= '0;
                        free_total_reg <= lim;
                        for (int q = 0; q < NUM_QUEUES; q++)
                        begin
                            queue_first_reg[q] <= NULL_LINK;
                            queue_last_reg[q]  <= '0;
                        end
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        swp_reg <= LW'(swp_reg + LW'(1));
                    end
                end
                S_RD:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    unique case (act_reg)
                        ACT_ALLOC:
                        begin
                            free_head_reg  <= lnk;
                            free_total_reg <= tot_dec;
                            res_reg        <= free_head_reg[IW-1:0];
                            state_reg      <= S_FIN;
                        end
                        ACT_FREE:
                        begin
                            if (bidx_ok)
                            begin
                                free_head_reg  <= LW'(bidx_reg);
                                free_total_reg <= tot_inc;
                            end
                            state_reg <= S_FIN;
                        end
                        ACT_QADD:
                        begin
                            free_head_reg  <= lnk;
                            free_total_reg <= tot_dec;
                            res_reg        <= free_head_reg[IW-1:0];
                            state_reg      <= S_LINK;
                        end
                        ACT_QTOP:
                        begin
                            queue_first_reg[qsel_reg] <= lnk;
                            free_head_reg             <= qf_cur;
                            free_total_reg            <= tot_inc;
                            res_reg                   <= qf_cur[IW-1:0];
                            state_reg                 <= S_FIN;
                        end
                        ACT_QDEL:
                        begin
                            free_head_reg  <= qf_cur;
                            free_total_reg <= tot_inc;
                            cnt_reg        <= LW'(cnt_reg + LW'(1));
                            if ((32'(cnt_reg) + 1 < BLOCK_COUNT) && !is_null(lnk))
                            begin
                                queue_first_reg[qsel_reg] <= lnk;
                                state_reg                 <= S_RD;
                            end
                            else
                            begin
                                queue_first_reg[qsel_reg] <= NULL_LINK;
                                state_reg                 <= S_FIN;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_LINK:
                begin
                    if (is_null(qf_cur))
                    begin
                        queue_first_reg[qsel_reg] <= LW'(res_reg);
                    end
                    queue_last_reg[qsel_reg] <= res_reg;
                    state_reg                <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.status        <= status_reg;
                        out_data_reg.result_index  <= res6;
                        out_data_reg.result_offset <= prod[17:0];
                        out_data_reg.free_count    <= 7'(free_total_reg);
                        out_valid_reg              <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/bpq_checker.sv =====
module bpq_checker #(
    parameter int BLOCK_COUNT = 64
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input bpq_pkg::out_t out_data
);

    import bpq_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == ST_OK || out_data.status == ST_POOL_EMPTY
            || out_data.status == ST_QUEUE_EMPTY)
        else $error("bad status code");

    // failed requests carry no block
    a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.result_index == '0 && out_data.result_offset == '0)
        else $error("block reported on failed request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> BLOCK_COUNT > 127 || 32'(out_data.free_count) <= BLOCK_COUNT)
        else $error("free count above pool size");

endmodule

bind block_pool_with_linked_queues bpq_checker #(
    .BLOCK_COUNT (BLOCK_COUNT)
) u_bpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpq_pkg::*;

    localparam int BLOCK_COUNT    = 64;
    localparam int NUM_QUEUES     = 4;
    localparam int NULL_LINK      = BLOCK_COUNT;
    localparam int PHASE_ITEMS    = 178;
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    typedef struct packed {
        in_t  req;
        logic typed;
        out_t res;
    } step_row_t;

    typedef struct packed {
        logic [12:0] blk_size;
        logic [6:0]  pool_blocks;
    } pool_cfg_t;

    localparam step_row_t DIRECTED[24] = '{
        '{'{ACT_ALLOC, 6'd0, 2'd0}, 1'b1, '{ST_POOL_EMPTY, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_QTOP, 6'd0, 2'd0}, 1'b1, '{ST_QUEUE_EMPTY, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_QDEL, 6'd0, 2'd3}, 1'b1, '{ST_QUEUE_EMPTY, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_QADD, 6'd0, 2'd1}, 1'b1, '{ST_POOL_EMPTY, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_RSVD6, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_RSVD7, 6'd63, 2'd3}, 1'b1, '{ST_OK, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_FREE, 6'd63, 2'd0}, 1'b1, '{ST_OK, 6'd0, 18'd0, 7'd1}},
        '{'{ACT_ALLOC, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd63, 18'd1008, 7'd0}},
        '{'{ACT_ALLOC, 6'd0, 2'd0}, 1'b1, '{ST_POOL_EMPTY, 6'd0, 18'd0, 7'd0}},
        '{'{ACT_INIT, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd0, 18'd0, 7'd64}},
        '{'{ACT_ALLOC, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd0, 18'd0, 7'd63}},
        '{'{ACT_ALLOC, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd1, 18'd16, 7'd62}},
        '{'{ACT_QADD, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd2, 18'd32, 7'd61}},
        '{'{ACT_QADD, 6'd0, 2'd3}, 1'b1, '{ST_OK, 6'd3, 18'd48, 7'd60}},
        '{'{ACT_QADD, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd4, 18'd64, 7'd59}},
        '{'{ACT_QTOP, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd2, 18'd32, 7'd60}},
        '{'{ACT_QTOP, 6'd0, 2'd0}, 1'b1, '{ST_OK, 6'd4, 18'd64, 7'd61}},
        '{'{ACT_QTOP, 6'd0, 2'd0}, 1'b1, '{ST_QUEUE_EMPTY, 6'd0, 18'd0, 7'd61}},
        '{'{ACT_QADD, 6'd21, 2'd3}, 1'b0, '0},
        '{'{ACT_QDEL, 6'd42, 2'd3}, 1'b0, '0},
        '{'{ACT_FREE, 6'd0, 2'd2}, 1'b0, '0},
        '{'{ACT_FREE, 6'd1, 2'd1}, 1'b0, '0},
        // double free, count saturates
        '{'{ACT_FREE, 6'd1, 2'd0}, 1'b0, '0},
        '{'{ACT_INIT, 6'd63, 2'd3}, 1'b0, '0}
    };

    localparam pool_cfg_t PHASES[8] = '{
        '{13'd8191, 7'd127},
        '{13'd1, 7'd1},
        '{13'd4096, 7'd64},
        '{13'd0, 7'd0},
        '{13'd100, 7'd5},
        '{13'd4095, 7'd2},
        '{13'd16, 7'd64},
        '{13'd777, 7'd33}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // pool model state
    bit [12:0] blk_bytes;
    bit [6:0]  blk_in_use;
    bit [6:0]  link_mem [BLOCK_COUNT];
    bit [6:0]  free_head;
    bit [6:0]  free_total;
    bit [6:0]  q_first [NUM_QUEUES];
    bit [5:0]  q_last [NUM_QUEUES];

    bit [5:0]    owned_blocks[$];
    out_t        pending_results[$];
    out_t        predicted;
    out_t        oldest_result;
    logic        typed_valid;
    out_t        typed_result;
    int unsigned req_count;
    int unsigned fail_count;
    int unsigned stall_cycles;
    logic        steady;

    assign steady = req_count >= 700 && req_count < 1000;

    block_pool_with_linked_queues u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit [6:0] pool_size();
        if (blk_in_use < 7'd1)
            return 7'd1;
        if (blk_in_use > 7'(BLOCK_COUNT))
            return 7'(BLOCK_COUNT);
        return blk_in_use;
    endfunction

    function automatic bit [6:0] link_of(bit [6:0] idx);
        if (idx >= BLOCK_COUNT)
            return 7'(NULL_LINK);
        return link_mem[idx[5:0]] >= BLOCK_COUNT ? 7'(NULL_LINK) : link_mem[idx[5:0]];
    endfunction

    function automatic void release_block(bit [6:0] idx);
        bit [6:0] lim;
        lim = pool_size();
        if (idx >= BLOCK_COUNT)
            return;
        link_mem[idx[5:0]] = free_head;
        free_head = idx;
        if (free_total < lim)
            free_total++;
        if (free_total > lim)
            free_total = lim;
    endfunction

    function automatic bit [6:0] take_block();
        bit [6:0] idx;
        idx = free_head;
        if (idx >= BLOCK_COUNT)
            return 7'(NULL_LINK);
        free_head = link_of(idx);
        if (free_total > 0)
            free_total--;
        return idx;
    endfunction

    function automatic void pool_reset();
        blk_bytes = BLOCK_BYTES_RST;
        blk_in_use = BLOCKS_IN_USE_RST;
        foreach (link_mem[i])
            link_mem[i] = '0;
        free_head = 7'(NULL_LINK);
        free_total = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            q_first[q] = 7'(NULL_LINK);
            q_last[q] = '0;
        end
    endfunction

    function automatic out_t pool_step(in_t req);
        out_t      res;
        bit [6:0]  n;
        bit [6:0]  idx;
        bit [1:0]  q;
        bit [18:0] prod;
        bit        have;
        res = '0;
        res.status = ST_OK;
        have = 1'b0;
        idx = '0;
        q = req.queue_id;
        case (req.action)
            ACT_INIT:
            begin
                n = pool_size();
                for (int i = 0; i + 1 < n; i++)
                    link_mem[i] = 7'(i + 1);
                link_mem[n - 1] = 7'(NULL_LINK);
                free_head = '0;
                free_total = n;
                for (int k = 0; k < NUM_QUEUES; k++)
                begin
                    q_first[k] = 7'(NULL_LINK);
                    q_last[k] = '0;
                end
                owned_blocks.delete();
            end
            ACT_ALLOC:
            begin
                idx = take_block();
                if (idx == NULL_LINK)
                    res.status = ST_POOL_EMPTY;
                else
                begin
                    have = 1'b1;
                    owned_blocks.push_back(idx[5:0]);
                end
            end
            ACT_FREE:
                release_block({1'b0, req.block_index});
            ACT_QADD:
            begin
                idx = take_block();
                if (idx == NULL_LINK)
                    res.status = ST_POOL_EMPTY;
                else
                begin
                    link_mem[idx[5:0]] = 7'(NULL_LINK);
                    if (q_first[q] < BLOCK_COUNT)
                        link_mem[q_last[q]] = idx;
                    else
                        q_first[q] = idx;
                    q_last[q] = idx[5:0];
                    have = 1'b1;
                end
            end
            ACT_QTOP:
            begin
                if (q_first[q] >= BLOCK_COUNT)
                    res.status = ST_QUEUE_EMPTY;
                else
                begin
                    idx = q_first[q];
                    q_first[q] = link_of(idx);
                    release_block(idx);
                    have = 1'b1;
                end
            end
            ACT_QDEL:
            begin
                if (q_first[q] >= BLOCK_COUNT)
                    res.status = ST_QUEUE_EMPTY;
                else
                begin
                    // bounded walk, a looped list cannot hang it
                    for (int i = 0; i < BLOCK_COUNT && q_first[q] < BLOCK_COUNT; i++)
                    begin
                        idx = q_first[q];
                        q_first[q] = link_of(idx);
                        release_block(idx);
                    end
                    q_first[q] = 7'(NULL_LINK);
                end
            end
            default:
                ;
        endcase
        if (have)
        begin
            prod = idx[5:0] * blk_bytes;
            res.result_index = idx[5:0];
            res.result_offset = prod[17:0];
        end
        res.free_count = free_total;
        return res;
    endfunction

    function automatic in_t random_request();
        in_t req;
        int  pick;
        int  slot;
        req.block_index = 6'($urandom);
        req.queue_id = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 18)
            req.action = ACT_ALLOC;
        else if (pick < 34)
        begin
            req.action = owned_blocks.size() > 0 ? ACT_FREE : ACT_ALLOC;
            if (owned_blocks.size() > 0)
            begin
                slot = $urandom_range(owned_blocks.size() - 1);
                req.block_index = owned_blocks[slot];
                owned_blocks.delete(slot);
            end
        end
        // free of any index, may hit a block in use
        else if (pick < 37)
            req.action = ACT_FREE;
        else if (pick < 65)
            req.action = ACT_QADD;
        else if (pick < 87)
            req.action = ACT_QTOP;
        else if (pick < 93)
            req.action = ACT_QDEL;
        else if (pick < 95)
            req.action = ACT_INIT;
        else
            req.action = $urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7;
        return req;
    endfunction

    task automatic send_request(input in_t req, input logic typed, input out_t res);
        while (!steady && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        typed_valid <= typed;
        typed_result <= res;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [12:0] size_bytes, input logic [6:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BLOCK_BYTES;
        cfg_data <= size_bytes;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= REG_BLOCKS_IN_USE;
        cfg_data <= CFG_DATA_W'(count);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_BLOCK_BYTES)
                blk_bytes = cfg_data;
            else
                blk_in_use = cfg_data[6:0];
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predicted = pool_step(in_data);
            pending_results.push_back(typed_valid ? typed_result : predicted);
            req_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending");
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("status", oldest_result.status, out_data.status);
                check_field("result_index", oldest_result.result_index,
                            out_data.result_index);
                check_field("result_offset", oldest_result.result_offset,
                            out_data.result_offset);
                check_field("free_count", oldest_result.free_count, out_data.free_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : receiver
        bit held_once;
        held_once = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            // long hold-off so the block backs up into its request side
            if (!held_once && req_count >= 300)
            begin
                held_once = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            out_ready <= steady || $urandom_range(99) >= 20;
        end
    end

    initial
    begin : stimulus
        in_t req;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BLOCK_BYTES;
        cfg_data = '0;
        typed_valid = 1'b0;
        typed_result = '0;
        req_count = 0;
        fail_count = 0;
        stall_cycles = 0;
        pool_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (DIRECTED[i])
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);
        foreach (PHASES[p])
        begin
            settle();
            write_config(PHASES[p].blk_size, PHASES[p].pool_blocks);
            req = random_request();
            req.action = ACT_INIT;
            send_request(req, 1'b0, '0);
            repeat (PHASE_ITEMS - 1) send_request(random_request(), 1'b0, '0);
        end
        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
